/* src/tfpg_pkg.sv */
// ----------------------------------------------------------------------------
// Text and frame pixel generator package
// Shared constants, codes and beat types for the pixel generator blocks.
// ----------------------------------------------------------------------------
package tfpg_pkg;

  localparam int TEXT_COLS    = 80;
  localparam int TEXT_ROWS    = 30;
  localparam int GLYPH_ROWS   = 16;
  localparam int FRAME_WIDTH  = 256;
  localparam int FRAME_HEIGHT = 192;

  localparam int WIN_TOP        = 22;
  localparam int WIN_LEFT       = 64;
  localparam int OVL_FIRST_CELL = 77;
  localparam int OVL_END_CELL   = 80;
  localparam logic [7:0] NIB    = 8'h0F;

  localparam int CELL_COUNT  = TEXT_COLS * TEXT_ROWS;
  localparam int FONT_COUNT  = 256 * GLYPH_ROWS;
  localparam int FRAME_COUNT = FRAME_WIDTH * FRAME_HEIGHT;

  localparam int CELL_AW     = $clog2(CELL_COUNT);
  localparam int FONT_AW     = $clog2(FONT_COUNT);
  localparam int FRAME_AW    = $clog2(FRAME_COUNT);
  localparam int GLYPH_ROW_W = $clog2(GLYPH_ROWS);
  localparam int JOB_ADDR_W  = (FRAME_AW > 16) ? FRAME_AW : 16;
  localparam int ADDR_CMP_W  = JOB_ADDR_W + 1;

  localparam int JOB_DEPTH = 4;
  localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_W = JOB_PTR_W + 1;
  localparam int OUT_DEPTH = 2;
  localparam int OUT_CNT_W = 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISPLAY_MODE   = 1'b0,
    CFG_OVERLAY_ENABLE = 1'b1
  } cfg_index_e;

  typedef enum logic [2:0] {
    ACT_WRITE_CHAR  = 3'd0,
    ACT_WRITE_ATTR  = 3'd1,
    ACT_WRITE_FONT  = 3'd2,
    ACT_WRITE_FRAME = 3'd3,
    ACT_RENDER      = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    JOB_CHAR      = 3'd0,
    JOB_ATTR      = 3'd1,
    JOB_FONT      = 3'd2,
    JOB_FRAME     = 3'd3,
    JOB_TEXT      = 3'd4,
    JOB_OVERLAY   = 3'd5,
    JOB_FRAME_PIX = 3'd6,
    JOB_BLANK     = 3'd7
  } job_kind_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [8:0]  scan_line;
    logic [9:0]  scan_column;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic [8:0] pixel_line;
    logic [9:0] pixel_column;
  } out_item_t;

  typedef struct packed {
    logic display_mode;
    logic overlay_enable;
  } cfg_t;

  typedef struct packed {
    job_kind_e              kind;
    logic [JOB_ADDR_W-1:0]  addr;
    logic [7:0]             data;
    logic [GLYPH_ROW_W-1:0] font_line;
    logic [2:0]             pix_bit;
    logic [8:0]             line;
    logic [9:0]             column;
  } job_t;

  function automatic logic job_is_render(input job_kind_e kind);
    logic r;
    r = (kind == JOB_TEXT) || (kind == JOB_OVERLAY) ||
        (kind == JOB_FRAME_PIX) || (kind == JOB_BLANK);
    return r;
  endfunction

endpackage

/* src/tfpg_front.sv */
// ----------------------------------------------------------------------------
// Pixel generator front end
// Classifies an incoming beat into a store write or a render job and works
// out the store addresses the back end needs.
// ----------------------------------------------------------------------------
module tfpg_front (
  input  tfpg_pkg::in_item_t item_i,
  input  tfpg_pkg::cfg_t     cfg_i,
  output tfpg_pkg::job_t     job_o,
  output logic               job_valid_o
);

  logic [8:0] crow;
  logic [6:0] ccol;
  logic [8:0] row_off;
  logic [9:0] col_off;
  logic       text_hit;
  logic       ovl_hit;
  logic       win_hit;
  logic [tfpg_pkg::ADDR_CMP_W-1:0] addr_ext;
  logic [tfpg_pkg::JOB_ADDR_W-1:0] cell_idx;
  logic [tfpg_pkg::JOB_ADDR_W-1:0] frame_idx;

  always_comb begin
    crow    = 9'(item_i.scan_line / tfpg_pkg::GLYPH_ROWS);
    ccol    = item_i.scan_column[9:3];
    row_off = 9'(item_i.scan_line - 9'(tfpg_pkg::WIN_TOP));
    col_off = 10'(item_i.scan_column - 10'(tfpg_pkg::WIN_LEFT));

    text_hit = (crow < 9'(tfpg_pkg::TEXT_ROWS)) && (ccol < 7'(tfpg_pkg::TEXT_COLS));
    ovl_hit  = cfg_i.overlay_enable &&
               (item_i.scan_line < 9'(tfpg_pkg::GLYPH_ROWS)) &&
               (ccol >= 7'(tfpg_pkg::OVL_FIRST_CELL)) &&
               (ccol < 7'(tfpg_pkg::OVL_END_CELL)) &&
               (ccol < 7'(tfpg_pkg::TEXT_COLS)) && (tfpg_pkg::TEXT_ROWS > 0);
    win_hit  = (item_i.scan_line >= 9'(tfpg_pkg::WIN_TOP)) &&
               (item_i.scan_line < 9'(tfpg_pkg::WIN_TOP + tfpg_pkg::FRAME_HEIGHT)) &&
               (item_i.scan_column >= 10'(tfpg_pkg::WIN_LEFT)) &&
               (item_i.scan_column < 10'(tfpg_pkg::WIN_LEFT + 2 * tfpg_pkg::FRAME_WIDTH));

    cell_idx  = tfpg_pkg::JOB_ADDR_W'(
                  tfpg_pkg::JOB_ADDR_W'(crow) * tfpg_pkg::JOB_ADDR_W'(tfpg_pkg::TEXT_COLS) +
                  tfpg_pkg::JOB_ADDR_W'(ccol));
    frame_idx = tfpg_pkg::JOB_ADDR_W'(
                  tfpg_pkg::JOB_ADDR_W'(row_off) *
                  tfpg_pkg::JOB_ADDR_W'(tfpg_pkg::FRAME_WIDTH) +
                  tfpg_pkg::JOB_ADDR_W'(col_off[9:1]));
    addr_ext  = tfpg_pkg::ADDR_CMP_W'(item_i.address);

    job_o.kind      = tfpg_pkg::JOB_BLANK;
    job_o.addr      = tfpg_pkg::JOB_ADDR_W'(item_i.address);
    job_o.data      = item_i.write_data;
    job_o.font_line = tfpg_pkg::GLYPH_ROW_W'(item_i.scan_line % tfpg_pkg::GLYPH_ROWS);
    job_o.pix_bit   = item_i.scan_column[2:0];
    job_o.line      = item_i.scan_line;
    job_o.column    = item_i.scan_column;
    job_valid_o     = 1'b0;

    case (tfpg_pkg::action_e'(item_i.action))
      tfpg_pkg::ACT_WRITE_CHAR: begin
        job_o.kind  = tfpg_pkg::JOB_CHAR;
        job_valid_o = addr_ext < tfpg_pkg::ADDR_CMP_W'(tfpg_pkg::CELL_COUNT);
      end
      tfpg_pkg::ACT_WRITE_ATTR: begin
        job_o.kind  = tfpg_pkg::JOB_ATTR;
        job_valid_o = addr_ext < tfpg_pkg::ADDR_CMP_W'(tfpg_pkg::CELL_COUNT);
      end
      tfpg_pkg::ACT_WRITE_FONT: begin
        job_o.kind  = tfpg_pkg::JOB_FONT;
        job_valid_o = addr_ext < tfpg_pkg::ADDR_CMP_W'(tfpg_pkg::FONT_COUNT);
      end
      tfpg_pkg::ACT_WRITE_FRAME: begin
        job_o.kind  = tfpg_pkg::JOB_FRAME;
        job_valid_o = addr_ext < tfpg_pkg::ADDR_CMP_W'(tfpg_pkg::FRAME_COUNT);
      end
      tfpg_pkg::ACT_RENDER: begin
        job_valid_o = 1'b1;
        if (!cfg_i.display_mode) begin
          job_o.kind = text_hit ? tfpg_pkg::JOB_TEXT : tfpg_pkg::JOB_BLANK;
          job_o.addr = cell_idx;
        end else if (ovl_hit) begin
          // Overlay cells live on cell row 0, so the cell index is the column.
          job_o.kind = tfpg_pkg::JOB_OVERLAY;
          job_o.addr = tfpg_pkg::JOB_ADDR_W'(ccol);
        end else if (win_hit) begin
          job_o.kind = tfpg_pkg::JOB_FRAME_PIX;
          job_o.addr = frame_idx;
        end else begin
          job_o.kind = tfpg_pkg::JOB_BLANK;
        end
      end
      default: begin
        job_valid_o = 1'b0;
      end
    endcase
  end

endmodule

/* src/tfpg_job_queue.sv */
// ----------------------------------------------------------------------------
// Pixel generator job queue
// Short first-in first-out queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module tfpg_job_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tfpg_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output tfpg_pkg::job_t head_o,
  output logic           empty_o
);

  tfpg_pkg::job_t                    mem_q [tfpg_pkg::JOB_DEPTH];
  logic [tfpg_pkg::JOB_PTR_W-1:0]    wr_q, wr_d;
  logic [tfpg_pkg::JOB_PTR_W-1:0]    rd_q, rd_d;
  logic [tfpg_pkg::JOB_CNT_W-1:0]    cnt_q, cnt_d;
  logic                              do_push;
  logic                              do_pop;

  assign full_o  = (cnt_q == tfpg_pkg::JOB_CNT_W'(tfpg_pkg::JOB_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? tfpg_pkg::JOB_PTR_W'(wr_q + 1'b1) : wr_q;
    rd_d  = do_pop ? tfpg_pkg::JOB_PTR_W'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = tfpg_pkg::JOB_CNT_W'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = tfpg_pkg::JOB_CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

/* src/tfpg_back.sv */
// ----------------------------------------------------------------------------
// Pixel generator back end
// Owns the four stores, carries out writes and renders, and holds finished
// pixels in a two-entry result buffer.
// ----------------------------------------------------------------------------
module tfpg_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfpg_pkg::job_t      head_i,
  input  logic                q_empty_i,
  output logic                q_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output tfpg_pkg::out_item_t result_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CELL = 3'b010,
    ST_FONT = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;
  tfpg_pkg::job_t job_q;

  logic [7:0] char_mem  [tfpg_pkg::CELL_COUNT];
  logic [7:0] attr_mem  [tfpg_pkg::CELL_COUNT];
  logic [7:0] font_mem  [tfpg_pkg::FONT_COUNT];
  logic [7:0] frame_mem [tfpg_pkg::FRAME_COUNT];

  logic [7:0] char_rd_q, attr_rd_q, font_rd_q, frame_rd_q;

  logic char_we, attr_we, font_we, frame_we;
  logic cell_re, frame_re, font_re;
  logic [tfpg_pkg::FONT_AW-1:0] font_ra;

  tfpg_pkg::out_item_t          out_mem_q [tfpg_pkg::OUT_DEPTH];
  logic                         out_wr_q, out_rd_q;
  logic [tfpg_pkg::OUT_CNT_W-1:0] out_cnt_q, out_cnt_d;
  logic                         out_full, out_push, out_pop;
  logic                         font_bit;
  logic [7:0]                   pixel;

  always_comb begin
    q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;
    char_we  = q_pop_o && (head_i.kind == tfpg_pkg::JOB_CHAR);
    attr_we  = q_pop_o && (head_i.kind == tfpg_pkg::JOB_ATTR);
    font_we  = q_pop_o && (head_i.kind == tfpg_pkg::JOB_FONT);
    frame_we = q_pop_o && (head_i.kind == tfpg_pkg::JOB_FRAME);
    cell_re  = q_pop_o && ((head_i.kind == tfpg_pkg::JOB_TEXT) ||
                           (head_i.kind == tfpg_pkg::JOB_OVERLAY));
    frame_re = q_pop_o && (head_i.kind == tfpg_pkg::JOB_FRAME_PIX);
    font_re  = (state_q == ST_CELL) && ((job_q.kind == tfpg_pkg::JOB_TEXT) ||
                                        (job_q.kind == tfpg_pkg::JOB_OVERLAY));
    font_ra  = tfpg_pkg::FONT_AW'(
                 tfpg_pkg::FONT_AW'(char_rd_q) * tfpg_pkg::FONT_AW'(tfpg_pkg::GLYPH_ROWS) +
                 tfpg_pkg::FONT_AW'(job_q.font_line));
  end

  // Store writes and reads; read data is registered.
  always_ff @(posedge clk_i) begin
    if (char_we) begin
      char_mem[head_i.addr[tfpg_pkg::CELL_AW-1:0]] <= head_i.data;
    end
    if (cell_re) begin
      char_rd_q <= char_mem[head_i.addr[tfpg_pkg::CELL_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (attr_we) begin
      attr_mem[head_i.addr[tfpg_pkg::CELL_AW-1:0]] <= head_i.data;
    end
    if (cell_re) begin
      attr_rd_q <= attr_mem[head_i.addr[tfpg_pkg::CELL_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (font_we) begin
      font_mem[head_i.addr[tfpg_pkg::FONT_AW-1:0]] <= head_i.data;
    end
    if (font_re) begin
      font_rd_q <= font_mem[font_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_mem[head_i.addr[tfpg_pkg::FRAME_AW-1:0]] <= head_i.data;
    end
    if (frame_re) begin
      frame_rd_q <= frame_mem[head_i.addr[tfpg_pkg::FRAME_AW-1:0]];
    end
  end

  always_comb begin
    font_bit = font_rd_q[job_q.pix_bit];
    case (job_q.kind)
      tfpg_pkg::JOB_TEXT: begin
        pixel = font_bit ? ((attr_rd_q >> 4) & tfpg_pkg::NIB) : (attr_rd_q & tfpg_pkg::NIB);
      end
      tfpg_pkg::JOB_OVERLAY: begin
        // The overlay paints its background as color 0.
        pixel = font_bit ? ((attr_rd_q >> 4) & tfpg_pkg::NIB) : 8'd0;
      end
      tfpg_pkg::JOB_FRAME_PIX: begin
        pixel = frame_rd_q;
      end
      default: begin
        pixel = 8'd0;
      end
    endcase
  end

  always_comb begin
    out_full = (out_cnt_q == tfpg_pkg::OUT_CNT_W'(tfpg_pkg::OUT_DEPTH));
    out_push = (state_q == ST_FONT) && !out_full;
    out_pop  = pop_i && (out_cnt_q != '0);
    out_cnt_d = out_cnt_q;
    if (out_push && !out_pop) begin
      out_cnt_d = tfpg_pkg::OUT_CNT_W'(out_cnt_q + 1'b1);
    end else if (out_pop && !out_push) begin
      out_cnt_d = tfpg_pkg::OUT_CNT_W'(out_cnt_q - 1'b1);
    end
  end

  assign empty_o  = (out_cnt_q == '0);
  assign result_o = out_mem_q[out_rd_q];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_pop_o && tfpg_pkg::job_is_render(head_i.kind)) begin
          state_d = ST_CELL;
        end
      end
      ST_CELL: begin
        state_d = ST_FONT;
      end
      ST_FONT: begin
        if (out_push) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_wr_q  <= 1'b0;
      out_rd_q  <= 1'b0;
      out_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      out_cnt_q <= out_cnt_d;
      if (out_push) begin
        out_wr_q <= ~out_wr_q;
      end
      if (out_pop) begin
        out_rd_q <= ~out_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= head_i;
    end
    if (out_push) begin
      out_mem_q[out_wr_q] <= '{pixel_value:  pixel,
                               pixel_line:   job_q.line,
                               pixel_column: job_q.column};
    end
  end

endmodule

/* src/text_and_frame_pixel_generator.sv */
// ----------------------------------------------------------------------------
// Text and frame pixel generator
// Renders 640x480 pixels from a character cell store or a frame store.
// ----------------------------------------------------------------------------
// Usage: input beats enter through push/full and carry either a store write
// (character, attribute, font byte or frame pixel) or a render request.
// A render beat yields one pixel beat on the result side, read through
// empty/pop; writes and unused actions yield nothing. Results come out in
// the order their render beats went in.
// A render beat passes through the back end's idle, cell and font states,
// as the font read depends on the character read from the cell store;
// its pixel then enters the result buffer and is shown with empty low. A
// write is done as the back end pops it. The input accepts up to four
// beats ahead of the back end; the result buffer holds two finished pixels.
// When the receiver stalls, the result buffer fills, the back end holds and
// full rises once the job queue is full; nothing is dropped.
// Reset clears the queues and sets text mode with the overlay enabled. The
// stores are not cleared; render only from entries that have been written.
// Configuration writes are to be made only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module text_and_frame_pixel_generator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  tfpg_pkg::in_item_t                  item_i,
  output logic                                empty,
  input  logic                                pop,
  output tfpg_pkg::out_item_t                 result_o,
  input  logic                                cfg_we_i,
  input  logic [tfpg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tfpg_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  tfpg_pkg::cfg_t cfg_q;
  tfpg_pkg::job_t front_job;
  tfpg_pkg::job_t head_job;
  logic           front_valid;
  logic           q_push;
  logic           q_pop;
  logic           q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.display_mode   <= 1'b0;
      cfg_q.overlay_enable <= 1'b1;
    end else if (cfg_we_i) begin
      case (tfpg_pkg::cfg_index_e'(cfg_index_i))
        tfpg_pkg::CFG_DISPLAY_MODE:   cfg_q.display_mode   <= cfg_data_i[0];
        tfpg_pkg::CFG_OVERLAY_ENABLE: cfg_q.overlay_enable <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  tfpg_front u_front (
    .item_i      (item_i),
    .cfg_i       (cfg_q),
    .job_o       (front_job),
    .job_valid_o (front_valid)
  );

  // Dropped beats are accepted but never reach the queue.
  assign q_push = push && !full && front_valid;

  tfpg_job_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (q_pop),
    .head_o  (head_job),
    .empty_o (q_empty)
  );

  tfpg_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head_job),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .result_o  (result_o)
  );

endmodule

/* src/tfpg_checker.sv */
// ----------------------------------------------------------------------------
// Pixel generator port checker
// Watches the top-level ports for reset, ordering and blank-region behavior.
// ----------------------------------------------------------------------------
module tfpg_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                full,
  input logic                pop,
  input logic                empty,
  input tfpg_pkg::out_item_t result_o
);

  // In the cycle after reset is seen low, both queues are clear.
  assert property (@(posedge clk_i) !rst_ni |=> (empty && !full))
    else $error("queues not clear during reset");

  // No pixel can come out straight after reset is released.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> empty ##1 empty ##1 empty)
    else $error("pixel beat too early after reset");

  // Anything past the visible 640x480 area renders as color 0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && ((result_o.pixel_line >= 9'd480) || (result_o.pixel_column >= 10'd640)))
    |-> (result_o.pixel_value == 8'd0))
    else $error("nonzero pixel outside the display");

  // A waiting pixel beat stays and holds its value until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("waiting pixel beat changed or vanished");

endmodule

bind text_and_frame_pixel_generator tfpg_checker u_tfpg_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .full     (full),
  .pop      (pop),
  .empty    (empty),
  .result_o (result_o)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel generator regression bench
// Fills the character, attribute, font and frame stores, then renders pixels
// in text mode and in native mode with the overlay on and off. A scoreboard
// class mirrors the stores and the mode registers and predicts every pixel
// beat. Both handshake sides idle at random. Renders only read store entries
// that were written earlier.
// ----------------------------------------------------------------------------
module tb_top;
  import tfpg_pkg::*;

  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
  localparam int ADDR_MAX      = 65535;
  localparam int DATA_MAX      = 255;
  localparam int LINE_MAX      = 511;
  localparam int COL_MAX       = 1023;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 1000;
  localparam int PHASE_BEATS   = 130;

  class pixel_scoreboard;
    bit [7:0]  char_cells [CELL_COUNT];
    bit [7:0]  attr_cells [CELL_COUNT];
    bit [7:0]  font_rows [FONT_COUNT];
    bit [7:0]  frame_pixels [FRAME_COUNT];
    bit        char_known [CELL_COUNT];
    bit        attr_known [CELL_COUNT];
    bit        font_known [FONT_COUNT];
    bit        frame_known [FRAME_COUNT];
    bit        native_mode;
    bit        overlay_on = 1'b1;
    out_item_t expected_pixels [$];
    int        beats;
    int        ignored;
    int        effective;
    int        text_pixels;
    int        native_pixels;
    int        errors;

    function void set_config(bit mode, bit ovl);
      native_mode = mode;
      overlay_on  = ovl;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // Pixel at display row y, column x; known is low when an unwritten
    // store entry would be read.
    function bit [7:0] pixel_at(int y, int x, output bit known);
      int  crow;
      int  ccol;
      int  cidx;
      int  fidx;
      int  idx;
      bit  lit;
      crow  = y / GLYPH_ROWS;
      ccol  = x / 8;
      known = 1'b1;
      if (!native_mode) begin
        if (crow >= TEXT_ROWS || ccol >= TEXT_COLS) return 8'd0;
        cidx = crow * TEXT_COLS + ccol;
      end else if (overlay_on && y < GLYPH_ROWS && ccol >= OVL_FIRST_CELL &&
                   ccol < OVL_END_CELL && ccol < TEXT_COLS) begin
        cidx = ccol;
      end else if (y >= WIN_TOP && y < WIN_TOP + FRAME_HEIGHT &&
                   x >= WIN_LEFT && x < WIN_LEFT + 2 * FRAME_WIDTH) begin
        idx   = (y - WIN_TOP) * FRAME_WIDTH + (x - WIN_LEFT) / 2;
        known = frame_known[idx];
        return frame_pixels[idx];
      end else begin
        return 8'd0;
      end
      fidx  = char_cells[cidx] * GLYPH_ROWS + y % GLYPH_ROWS;
      known = char_known[cidx] && attr_known[cidx] && font_known[fidx];
      lit   = font_rows[fidx][x % 8];
      if (lit) return (attr_cells[cidx] >> 4) & NIB;
      // The overlay draws its cells on a zero background.
      return native_mode ? 8'd0 : attr_cells[cidx] & NIB;
    endfunction

    function void note_input(in_item_t beat);
      int        a;
      bit        known;
      out_item_t want;
      a = beat.address;
      beats++;
      case (beat.action)
        ACT_WRITE_CHAR: begin
          if (a < CELL_COUNT) begin
            char_cells[a] = beat.write_data;
            char_known[a] = 1'b1;
          end else ignored++;
        end
        ACT_WRITE_ATTR: begin
          if (a < CELL_COUNT) begin
            attr_cells[a] = beat.write_data;
            attr_known[a] = 1'b1;
          end else ignored++;
        end
        ACT_WRITE_FONT: begin
          if (a < FONT_COUNT) begin
            font_rows[a]  = beat.write_data;
            font_known[a] = 1'b1;
          end else ignored++;
        end
        ACT_WRITE_FRAME: begin
          if (a < FRAME_COUNT) begin
            frame_pixels[a] = beat.write_data;
            frame_known[a]  = 1'b1;
          end else ignored++;
        end
        ACT_RENDER: begin
          want.pixel_value  = pixel_at(beat.scan_line, beat.scan_column, known);
          want.pixel_line   = beat.scan_line;
          want.pixel_column = beat.scan_column;
          expected_pixels.push_back(want);
          if (native_mode) native_pixels++;
          else text_pixels++;
        end
        default: ignored++;
      endcase
      effective = beats - ignored;
    endfunction

    task report(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_pixels.size() == 0) begin
        report($sformatf("pixel beat line %0d column %0d with no render outstanding",
                         got.pixel_line, got.pixel_column));
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_value !== want.pixel_value)
        report($sformatf("value %0h, want %0h at line %0d column %0d", got.pixel_value,
                         want.pixel_value, want.pixel_line, want.pixel_column));
      if (got.pixel_line !== want.pixel_line)
        report($sformatf("line %0d, want %0d", got.pixel_line, want.pixel_line));
      if (got.pixel_column !== want.pixel_column)
        report($sformatf("column %0d, want %0d", got.pixel_column, want.pixel_column));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  in_item_t              in_beat = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  out_item_t             out_beat;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  pixel_scoreboard sb = new();
  int idle_cycles = 0;
  int tx_run = 0;
  bit tx_calm = 1'b0;
  int rx_run = 0;
  bit rx_calm = 1'b0;

  text_and_frame_pixel_generator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (in_beat),
    .empty       (empty),
    .pop         (pop),
    .result_o    (out_beat),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Idle cycles before the next beat; stretches of back-to-back beats in between.
  function automatic int draw_gap(ref int run_left, ref bit calm);
    if (run_left == 0) begin
      calm     = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(8, 40);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic send_beat(logic [2:0] act, int addr, int data, int y, int x);
    in_item_t beat;
    int       gap;
    beat.action      = act;
    beat.address     = addr[15:0];
    beat.write_data  = data[7:0];
    beat.scan_line   = y[8:0];
    beat.scan_column = x[9:0];
    gap = draw_gap(tx_run, tx_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_beat <= beat;
    do @(posedge clk_i); while (full);
    sb.note_input(beat);
  endtask

  task automatic render(int y, int x);
    send_beat(ACT_RENDER, $urandom_range(0, ADDR_MAX), $urandom_range(0, DATA_MAX), y, x);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // Writes leave no result, so give the back end time to retire them.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reconfigure(bit mode, bit ovl);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_DISPLAY_MODE;
    cfg_data_i  <= mode;
    @(posedge clk_i);
    cfg_index_i <= CFG_OVERLAY_ENABLE;
    cfg_data_i  <= ovl;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_config(mode, ovl);
  endtask

  // Writes one cell, its attribute and one glyph row, then renders from it.
  task automatic cell_sequence(bit overlay_cells);
    int crow;
    int ccol;
    int cidx;
    int ch;
    int grow;
    crow = overlay_cells ? 0 : $urandom_range(0, TEXT_ROWS - 1);
    ccol = overlay_cells ? $urandom_range(OVL_FIRST_CELL, OVL_END_CELL - 1)
                         : $urandom_range(0, TEXT_COLS - 1);
    cidx = crow * TEXT_COLS + ccol;
    ch   = $urandom_range(0, 255);
    grow = $urandom_range(0, GLYPH_ROWS - 1);
    send_beat(ACT_WRITE_CHAR, cidx, ch, $urandom_range(0, LINE_MAX), $urandom_range(0, COL_MAX));
    send_beat(ACT_WRITE_ATTR, cidx, $urandom_range(0, DATA_MAX), $urandom_range(0, LINE_MAX),
              $urandom_range(0, COL_MAX));
    send_beat(ACT_WRITE_FONT, ch * GLYPH_ROWS + grow, $urandom_range(0, DATA_MAX),
              $urandom_range(0, LINE_MAX), $urandom_range(0, COL_MAX));
    repeat ($urandom_range(1, 4))
      render(crow * GLYPH_ROWS + grow, ccol * 8 + $urandom_range(0, 7));
  endtask

  task automatic frame_sequence();
    int row;
    int col;
    row = $urandom_range(0, FRAME_HEIGHT - 1);
    col = $urandom_range(0, FRAME_WIDTH - 1);
    send_beat(ACT_WRITE_FRAME, row * FRAME_WIDTH + col, $urandom_range(0, DATA_MAX),
              $urandom_range(0, LINE_MAX), $urandom_range(0, COL_MAX));
    if ($urandom_range(0, 1)) render(WIN_TOP + row, WIN_LEFT + 2 * col);
    render(WIN_TOP + row, WIN_LEFT + 2 * col + 1);
  endtask

  task automatic random_render();
    int y;
    int x;
    int tries;
    bit known;
    tries = 0;
    do begin
      if ($urandom_range(0, 1)) begin
        y = $urandom_range(0, LINE_MAX);
        x = $urandom_range(0, COL_MAX);
      end else begin
        y = $urandom_range(0, 479);
        x = $urandom_range(0, 639);
      end
      void'(sb.pixel_at(y, x, known));
      tries++;
    end while (!known && tries < 16);
    // Lines past the text grid and the frame window read no store.
    if (!known) y = $urandom_range(480, LINE_MAX);
    render(y, x);
  endtask

  task automatic random_phase(int target);
    int         goal;
    int         pick;
    int         span;
    int         addr;
    logic [2:0] act;
    goal = sb.effective + target;
    while (sb.effective < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        wait_drained();
      end else if (pick < 40) begin
        if (!sb.native_mode) cell_sequence($urandom_range(0, 4) == 0);
        else if ($urandom_range(0, 2) == 0) cell_sequence(1'b1);
        else frame_sequence();
      end else if (pick < 65) begin
        random_render();
      end else if (pick < 92) begin
        act  = 3'($urandom_range(int'(ACT_WRITE_CHAR), int'(ACT_WRITE_FRAME)));
        span = (act == ACT_WRITE_FONT) ? FONT_COUNT :
               (act == ACT_WRITE_FRAME) ? FRAME_COUNT : CELL_COUNT;
        addr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ADDR_MAX)
                                           : $urandom_range(0, span - 1);
        send_beat(act, addr, $urandom_range(0, DATA_MAX), $urandom_range(0, LINE_MAX),
                  $urandom_range(0, COL_MAX));
      end else begin
        send_beat(3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)),
                  $urandom_range(0, ADDR_MAX), $urandom_range(0, DATA_MAX),
                  $urandom_range(0, LINE_MAX), $urandom_range(0, COL_MAX));
      end
    end
  endtask

  // Result side: pops with random stalls and checks every pixel beat.
  initial begin
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = draw_gap(rx_run, rx_calm);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      sb.check_result(out_beat);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("Stalled for %0d cycles with %0d pixels outstanding", STALL_LIMIT, sb.pending());
    $display("text_and_frame_pixel_generator regression: fail");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Text mode: glyph bits at both ends of a byte, the last cell, off-grid pixels.
    reconfigure(1'b0, 1'b1);
    send_beat(ACT_WRITE_CHAR, 0, 8'hFF, 0, 0);
    send_beat(ACT_WRITE_ATTR, 0, 8'h5A, 0, 0);
    send_beat(ACT_WRITE_FONT, 255 * GLYPH_ROWS, 8'h81, 0, 0);
    render(0, 0);
    render(0, 1);
    render(0, 7);
    send_beat(ACT_WRITE_CHAR, CELL_COUNT - 1, 0, LINE_MAX, COL_MAX);
    send_beat(ACT_WRITE_ATTR, CELL_COUNT - 1, 8'hF0, LINE_MAX, COL_MAX);
    send_beat(ACT_WRITE_FONT, GLYPH_ROWS - 1, 8'h7F, LINE_MAX, COL_MAX);
    render(479, 639);
    render(479, 632);
    render(480, 0);
    render(LINE_MAX, COL_MAX);
    render(0, 640);
    send_beat(ACT_WRITE_CHAR, CELL_COUNT, DATA_MAX, 0, 0);
    send_beat(ACT_WRITE_FONT, FONT_COUNT, DATA_MAX, 0, 0);
    send_beat(ACT_WRITE_FRAME, FRAME_COUNT, DATA_MAX, 0, 0);
    send_beat(ACT_WRITE_ATTR, ADDR_MAX, DATA_MAX, 0, 0);
    for (int code = ACT_UNUSED_LO; code <= ACT_UNUSED_HI; code++)
      send_beat(3'(code), ADDR_MAX, DATA_MAX, LINE_MAX, COL_MAX);
    send_beat(ACT_WRITE_FRAME, 0, 8'hC3, 0, 0);
    send_beat(ACT_WRITE_FRAME, FRAME_COUNT - 1, DATA_MAX, 0, 0);
    send_beat(ACT_WRITE_CHAR, OVL_FIRST_CELL, 1, 0, 0);
    send_beat(ACT_WRITE_ATTR, OVL_FIRST_CELL, 8'hE3, 0, 0);
    send_beat(ACT_WRITE_FONT, GLYPH_ROWS, 8'h01, 0, 0);
    render(0, OVL_FIRST_CELL * 8);

    // Native mode: window corners, pixels just outside it, overlay cells.
    reconfigure(1'b1, 1'b1);
    render(WIN_TOP, WIN_LEFT);
    render(WIN_TOP, WIN_LEFT + 1);
    render(WIN_TOP + FRAME_HEIGHT - 1, WIN_LEFT + 2 * FRAME_WIDTH - 1);
    render(WIN_TOP - 1, WIN_LEFT);
    render(WIN_TOP + FRAME_HEIGHT, WIN_LEFT + 2 * FRAME_WIDTH);
    render(0, OVL_FIRST_CELL * 8);
    render(0, OVL_FIRST_CELL * 8 + 1);
    reconfigure(1'b1, 1'b0);
    render(0, OVL_FIRST_CELL * 8);
    render(WIN_TOP, WIN_LEFT - 1);

    random_phase(PHASE_BEATS);
    reconfigure(1'b0, 1'b0);
    random_phase(PHASE_BEATS);
    reconfigure(1'b1, 1'b1);
    random_phase(PHASE_BEATS);
    reconfigure(1'b0, 1'b1);
    random_phase(PHASE_BEATS);
    wait_drained();

    $display("Sent %0d input beats (%0d ignored); checked %0d text and %0d native pixels,",
             sb.beats, sb.ignored, sb.text_pixels, sb.native_pixels);
    $display("in both display modes with the overlay on and off; %0d mismatches.", sb.errors);
    if (sb.errors == 0) begin
      $display("text_and_frame_pixel_generator regression: pass");
    end else begin
      $display("text_and_frame_pixel_generator regression: fail");
    end
    $finish;
  end

endmodule
